### rtl/qcpn_pkg.sv
// Package for the quaternion chain product block: widths, command and status structs.
// No dependencies.
`default_nettype none
package qcpn_pkg;
  localparam int IN_W = 16;
  localparam int ACC_W = 32;
  localparam int CFG_W = 25;
  localparam int SUM_W = 64;
  localparam int LEN_W = 32;
  localparam int QUO_W = 17;

  typedef struct packed {
    logic       clear;      // return accumulator to identity
    logic       load_in;    // capture input quaternion
    logic       acc_load;   // copy the finished product into the accumulator
    logic       mac;        // one product term
    logic [1:0] comp;       // component index
    logic [1:0] term;       // term index
    logic       commit;     // write product component
    logic       sq;         // square and add one component
    logic       sqrt_start;
    logic       sqrt_step;
    logic       div_start;
    logic       div_step;
    logic       finish;     // write one output component
  } qcpn_cmd_t;

  typedef struct packed {
    logic len_ok;
  } qcpn_sts_t;
endpackage
`default_nettype wire

### rtl/qcpn_if.sv
// Valid/ready channel interfaces for the quaternion block.
// Depends on qcpn_pkg.
`default_nettype none
interface qcpn_in_if import qcpn_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [IN_W-1:0] in_x, in_y, in_z, in_w;
  logic last;
  modport source (output valid, in_x, in_y, in_z, in_w, last, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, last, output ready);
endinterface

interface qcpn_out_if import qcpn_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [IN_W-1:0] out_x, out_y, out_z, out_w;
  logic normalized;
  modport source (output valid, out_x, out_y, out_z, out_w, normalized, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, normalized, output ready);
endinterface
`default_nettype wire

### rtl/qcpn_datapath.sv
// Datapath: accumulator, a 32x16 product multiplier and a 32x32 squarer, bit-serial square root and divider.
// Depends on qcpn_pkg.
`default_nettype none
module qcpn_datapath import qcpn_pkg::*; #(
  parameter int ACC_FRAC_BITS = 24,
  parameter int IN_FRAC_BITS = 15
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire qcpn_cmd_t cmd_i,
  output qcpn_sts_t sts_o,
  input  wire logic [CFG_W-1:0] min_length_i,
  input  wire logic signed [IN_W-1:0] in_x_i, in_y_i, in_z_i, in_w_i,
  output logic signed [IN_W-1:0] res_o [4]
);
  localparam logic signed [ACC_W-1:0] ONE = ACC_W'(64'd1 << ACC_FRAC_BITS);
  localparam int SH = ACC_FRAC_BITS - IN_FRAC_BITS;

  logic signed [ACC_W-1:0] acc_q [4];
  logic signed [ACC_W-1:0] nacc_q [4];
  logic signed [IN_W-1:0] b_q [4];
  logic signed [49:0] sum_q;
  logic [SUM_W-1:0] ssq_q;
  logic [SUM_W-1:0] rem_q, res_q, bit_q;
  logic [LEN_W-1:0] len_q;
  logic [SUM_W-1:0] num_q, drem_q;
  logic [QUO_W-1:0] quo_q;

  // Hamilton product term table: acc index, b index, subtract
  logic [1:0] ai, bi;
  logic neg;
  always_comb begin
    ai = cmd_i.term; bi = 2'd0; neg = 1'b0;
    case ({cmd_i.comp, cmd_i.term})
      4'h0: begin ai = 2'd3; bi = 2'd0; end
      4'h1: begin ai = 2'd0; bi = 2'd3; end
      4'h2: begin ai = 2'd1; bi = 2'd2; end
      4'h3: begin ai = 2'd2; bi = 2'd1; neg = 1'b1; end
      4'h4: begin ai = 2'd3; bi = 2'd1; end
      4'h5: begin ai = 2'd0; bi = 2'd2; neg = 1'b1; end
      4'h6: begin ai = 2'd1; bi = 2'd3; end
      4'h7: begin ai = 2'd2; bi = 2'd0; end
      4'h8: begin ai = 2'd3; bi = 2'd2; end
      4'h9: begin ai = 2'd0; bi = 2'd1; end
      4'hA: begin ai = 2'd1; bi = 2'd0; neg = 1'b1; end
      4'hB: begin ai = 2'd2; bi = 2'd3; end
      4'hC: begin ai = 2'd3; bi = 2'd3; end
      4'hD: begin ai = 2'd0; bi = 2'd0; neg = 1'b1; end
      4'hE: begin ai = 2'd1; bi = 2'd1; neg = 1'b1; end
      4'hF: begin ai = 2'd2; bi = 2'd2; neg = 1'b1; end
      default: ;
    endcase
  end

  logic signed [47:0] prod;
  logic signed [49:0] sum_d, rnd;
  logic signed [ACC_W-1:0] sat_v;
  assign prod = acc_q[ai] * b_q[bi];
  assign sum_d = (cmd_i.term == 2'd0 ? 50'sd0 : sum_q) + (neg ? -50'(prod) : 50'(prod));
  assign rnd = (sum_q + (50'sd1 <<< (IN_FRAC_BITS - 1))) >>> IN_FRAC_BITS;
  always_comb begin
    if (rnd > 50'sd2147483647) sat_v = 32'sh7FFFFFFF;
    else if (rnd < -50'sd2147483648) sat_v = 32'sh80000000;
    else sat_v = rnd[ACC_W-1:0];
  end

  // squares
  logic [ACC_W-1:0] mag;
  logic [SUM_W-1:0] sqv;
  logic [SUM_W:0] ssq_add;
  assign mag = acc_q[cmd_i.comp][ACC_W-1] ? -acc_q[cmd_i.comp] : acc_q[cmd_i.comp];
  assign sqv = mag * mag;
  assign ssq_add = {1'b0, (cmd_i.comp == 2'd0 ? 64'd0 : ssq_q)} + {1'b0, sqv};

  // sqrt step
  logic [SUM_W-1:0] rb;
  assign rb = res_q + bit_q;

  // divider
  logic [ACC_W-1:0] cm;
  logic [SUM_W:0] dtry;
  assign cm = acc_q[cmd_i.comp][ACC_W-1] ? -acc_q[cmd_i.comp] : acc_q[cmd_i.comp];
  assign dtry = {drem_q, num_q[SUM_W-1]} - {33'd0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0; acc_q[3] <= ONE;
    end else if (cmd_i.clear) begin
      acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0; acc_q[3] <= ONE;
    end else if (cmd_i.acc_load) begin
      acc_q <= nacc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      b_q[0] <= in_x_i; b_q[1] <= in_y_i; b_q[2] <= in_z_i; b_q[3] <= in_w_i;
    end
    if (cmd_i.mac) sum_q <= sum_d;
    if (cmd_i.commit) nacc_q[cmd_i.comp] <= sat_v;
    if (cmd_i.sq) ssq_q <= ssq_add[SUM_W] ? '1 : ssq_add[SUM_W-1:0];
    if (cmd_i.sqrt_start) begin
      rem_q <= ssq_q; res_q <= '0; bit_q <= 64'd1 << 62;
    end else if (cmd_i.sqrt_step) begin
      if (bit_q != 0) begin
        if (rem_q >= rb) begin rem_q <= rem_q - rb; res_q <= (res_q >> 1) + bit_q; end
        else res_q <= res_q >> 1;
        bit_q <= bit_q >> 2;
      end
      len_q <= res_q[LEN_W-1:0];
    end
    if (cmd_i.div_start) begin
      num_q <= (SUM_W'(cm) << IN_FRAC_BITS) + SUM_W'(len_q >> 1);
      drem_q <= '0; quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      if (!dtry[SUM_W]) begin drem_q <= dtry[SUM_W-1:0]; quo_q <= {quo_q[QUO_W-2:0], 1'b1} | {QUO_W{quo_q[QUO_W-1]}}; end
      else begin drem_q <= {drem_q[SUM_W-2:0], num_q[SUM_W-1]}; quo_q <= {quo_q[QUO_W-2:0], 1'b0} | {QUO_W{quo_q[QUO_W-1]}}; end
    end
  end

  // output component
  logic signed [ACC_W:0] pr;
  logic signed [IN_W-1:0] pv, nv;
  logic [QUO_W-1:0] qs;
  assign pr = ($signed({acc_q[cmd_i.comp][ACC_W-1], acc_q[cmd_i.comp]})
               + (33'sd1 <<< (SH - 1))) >>> SH;
  assign qs = quo_q[QUO_W-1] ? 17'd32768 : quo_q;
  always_comb begin
    if (pr > 33'sd32767) pv = 16'sh7FFF;
    else if (pr < -33'sd32768) pv = 16'sh8000;
    else pv = pr[IN_W-1:0];
    if (acc_q[cmd_i.comp][ACC_W-1]) nv = (qs >= 17'd32768) ? 16'sh8000 : -$signed(qs[IN_W-1:0]);
    else nv = (qs >= 17'd32767) ? 16'sh7FFF : $signed(qs[IN_W-1:0]);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) res_o[cmd_i.comp] <= sts_o.len_ok ? nv : pv;
  end
  assign sts_o.len_ok = {7'd0, len_q} > {14'd0, min_length_i};
endmodule
`default_nettype wire

### rtl/qcpn_ctrl.sv
// Controller sequencing product, length and division steps.
// Depends on qcpn_pkg.
`default_nettype none
module qcpn_ctrl import qcpn_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output qcpn_cmd_t cmd_o,
  input  wire qcpn_sts_t sts_i
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MAC = 3'd1, S_APPLY = 3'd2, S_SQ = 3'd3,
                         S_SQRT = 3'd4, S_DIV = 3'd5, S_OUT = 3'd6;
  logic [2:0] state_q, state_d;
  logic [1:0] comp_q, comp_d, term_q, term_d;
  logic [6:0] cnt_q, cnt_d;
  logic last_q, last_d, ov_q, ov_d;

  assign in_ready_o = state_q == S_IDLE;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q; comp_d = comp_q; term_d = term_q; cnt_d = cnt_q;
    last_d = last_q; ov_d = ov_q && !out_ready_i;
    cmd_o = '0; cmd_o.comp = comp_q; cmd_o.term = term_q;
    case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        cmd_o.load_in = 1'b1; last_d = in_last_i; state_d = S_MAC;
        comp_d = '0; term_d = '0;
      end
      S_MAC: begin
        cmd_o.mac = 1'b1; term_d = term_q + 2'd1;
        if (term_q == 2'd3) state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.commit = 1'b1; comp_d = comp_q + 2'd1;
        if (comp_q == 2'd3) begin
          state_d = S_SQ; comp_d = '0;
        end else state_d = S_MAC;
      end
      S_SQ: begin
        if (cnt_q == 7'd0) begin cmd_o.acc_load = 1'b1; cnt_d = 7'd1; end
        else if (!last_q) begin state_d = S_IDLE; cnt_d = '0; end
        else begin
          cmd_o.sq = 1'b1; comp_d = comp_q + 2'd1;
          if (comp_q == 2'd3) begin state_d = S_SQRT; cmd_o.sqrt_start = 1'b0; cnt_d = '0; end
        end
      end
      S_SQRT: begin
        if (cnt_q == 7'd0) cmd_o.sqrt_start = 1'b1; else cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd33) begin state_d = S_DIV; cnt_d = '0; comp_d = '0; end
      end
      S_DIV: begin
        if (cnt_q == 7'd0) cmd_o.div_start = 1'b1;
        else cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64 || !sts_i.len_ok) begin state_d = S_OUT; cnt_d = '0; end
      end
      S_OUT: begin
        // hold the write-out while the previous result waits
        if (!ov_q) begin
          cmd_o.finish = 1'b1; comp_d = comp_q + 2'd1;
          if (comp_q == 2'd3) begin
            cmd_o.clear = 1'b1; ov_d = 1'b1; state_d = S_IDLE; comp_d = '0;
          end else state_d = S_DIV;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; comp_q <= '0; term_q <= '0; cnt_q <= '0; last_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; comp_q <= comp_d; term_q <= term_d; cnt_q <= cnt_d;
      last_q <= last_d; ov_q <= ov_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !cmd_o.finish) else $error("result overwritten while pending");
  a_ov_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q) else $error("result dropped");
  a_clear_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> ov_q) else $error("clear without result");
`endif
endmodule
`default_nettype wire

### rtl/quaternion_chain_product_normalize_top.sv
// Sequence: a request without last runs a 4x4 multiply-accumulate, 4 commits and an
// accumulator update; a last request then adds 4 squares, the root and, per component, a
// divide and a write, with no divide steps when the length is at or below min_length.
// Throughput: one request at a time, set by the shared 32x16 multiplier and the bit-serial
// root and divider; a pending result stalls only the final write-out.
// Reset (async, active low) sets identity and min_length 1678. Depends on qcpn_pkg, qcpn_if.
`default_nettype none
module quaternion_chain_product_normalize_top import qcpn_pkg::*; #(
  parameter int ACC_FRAC_BITS = 24,
  parameter int IN_FRAC_BITS = 15
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  qcpn_in_if.sink in_if,
  qcpn_out_if.source out_if,
  input wire logic cfg_we_i,
  input wire logic [CFG_W-1:0] cfg_wdata_i
);
  logic [CFG_W-1:0] min_length_q;
  qcpn_cmd_t cmd;
  qcpn_sts_t sts;
  logic signed [IN_W-1:0] res [4];

  // hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) min_length_q <= CFG_W'(1678);
    else if (cfg_we_i) min_length_q <= cfg_wdata_i;
  end

  qcpn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_last_i(in_if.last),
    .in_ready_o(in_if.ready), .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  qcpn_datapath #(.ACC_FRAC_BITS(ACC_FRAC_BITS), .IN_FRAC_BITS(IN_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .min_length_i(min_length_q),
    .in_x_i(in_if.in_x), .in_y_i(in_if.in_y), .in_z_i(in_if.in_z), .in_w_i(in_if.in_w),
    .res_o(res)
  );

  logic norm_q;
  always_ff @(posedge clk_i) if (cmd.finish) norm_q <= sts.len_ok;
  assign out_if.out_x = res[0];
  assign out_if.out_y = res[1];
  assign out_if.out_z = res[2];
  assign out_if.out_w = res[3];
  assign out_if.normalized = norm_q;
endmodule
`default_nettype wire
